### rtl/contiguous_block_allocator_top_defines.svh
// Assertion macros used by the checker file.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst
`define CBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst
`define CBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cba_pkg.sv
`timescale 1ns / 1ps
package cba_pkg;

  // Default geometry
  localparam int NUM_BLOCKS_DEF  = 256;
  localparam int BLOCK_BYTES_DEF = 512;
  localparam int NUM_FILES_DEF   = 16;

  // Fixed field widths
  localparam int SIZE_W   = 20;
  localparam int ENTRY_W  = 4;
  localparam int FIRST_W  = 8;
  localparam int COUNT_W  = 12;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 24;

  // Dividend width for the round-up divide: size plus block size minus one
  localparam int DVD_W = SIZE_W + 1;

  // Request kinds
  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_SIZE_ZERO  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NO_SPACE   = 3'd3,
    ST_BAD_ENTRY  = 3'd4
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;      // item accepted, capture request
    logic    clr;       // clearing pass step
    logic    scan_go;   // start first-fit scan
    logic    commit;    // record entry, arm mark walk
    logic    dload;     // latch entry run, drop entry valid
    logic    walk;      // write one block of the run
    logic    mark;      // write data for the walk
    logic    res_load;  // load output register
    status_t res_code;
  } cba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic scan_done;
    logic ent_found;
    logic blk_found;
    logic walk_last;
    logic size_zero;
    logic del_bad;
    logic op;
    logic out_free;
  } cba_stat_t;

endpackage

### rtl/contiguous_block_allocator_top.sv
`timescale 1ns / 1ps
// First-fit contiguous block allocator.
// Input channel s_*: one request item per handshake. s_tuser is the kind
// (0 create, 1 delete); s_tdata carries the byte size and the entry index.
// Output channel m_*: exactly one result item per request. m_tuser is the
// status; m_tdata carries entry, start block and block count (zero on error).
// One request is in work at a time; s_tready is high only while idle.
// Create: after the accept the size is rounded up to blocks, then a first-fit
// scan runs (one block a cycle, paced by the block-map RAM read port; the
// free-entry search runs alongside), the blocks of the run are marked and
// the output is loaded. Delete: the entry's run is read from the table and
// latched, its blocks are freed and the output is loaded. Size zero and bad
// entry go from the accept straight to the result stage; table full and no
// space come once both searches have ended.
// A new request is taken the cycle after the result is loaded.
// After reset a clearing pass zeroes all NUM_BLOCKS blocks of the block
// map, one block a cycle, with s_tready low. If m_tready is low the result
// is held in the output register; the next request is still taken, and it
// waits at its end until the register is free.
module contiguous_block_allocator_top
  import cba_pkg::*;
#(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int NUM_FILES   = NUM_FILES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [DATA_W-1:0]   s_tdata,   // size_bytes[19:0], entry_index[23:20]
  input  logic                s_tuser,   // op[0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [DATA_W-1:0]   m_tdata,   // entry_out[3:0], first_block[11:4],
                                         // run_blocks[23:12]
  output logic [STATUS_W-1:0] m_tuser    // status[2:0]
);

  cba_cmd_t            cmd;
  cba_stat_t           stat;
  status_t             status;
  logic [ENTRY_W-1:0]  entry_out;
  logic [FIRST_W-1:0]  first_block;
  logic [COUNT_W-1:0]  run_blocks;

  cba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cba_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_FILES   (NUM_FILES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .op          (s_tuser),
    .size_bytes  (s_tdata[SIZE_W-1:0]),
    .entry_index (s_tdata[SIZE_W+ENTRY_W-1:SIZE_W]),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .status      (status),
    .entry_out   (entry_out),
    .first_block (first_block),
    .run_blocks  (run_blocks)
  );

  // Pack the result item
  assign m_tdata = {run_blocks, first_block, entry_out};
  assign m_tuser = status;

endmodule

### rtl/cba_ram.sv
`timescale 1ns / 1ps
module cba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/cba_ctrl.sv
`timescale 1ns / 1ps
module cba_ctrl
  import cba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  cba_stat_t stat,
  output cba_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_MARK  = 9'b000010000,
    S_DREAD = 9'b000100000,
    S_DLOAD = 9'b001000000,
    S_FREE  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t  state, state_next;
  status_t code, code_next;

  // Sequence one request
  always_comb begin
    state_next   = state;
    code_next    = code;
    cmd          = '0;
    cmd.res_code = code;
    s_tready     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (stat.op == OP_CREATE) begin
            if (stat.size_zero) begin
              code_next  = ST_SIZE_ZERO;
              state_next = S_DONE;
            end else begin
              state_next = S_DIV;
            end
          end else if (stat.del_bad) begin
            code_next  = ST_BAD_ENTRY;
            state_next = S_DONE;
          end else begin
            state_next = S_DREAD;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.scan_go = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (!stat.ent_found) begin
            code_next  = ST_TABLE_FULL;
            state_next = S_DONE;
          end else if (!stat.blk_found) begin
            code_next  = ST_NO_SPACE;
            state_next = S_DONE;
          end else begin
            cmd.commit = 1'b1;
            code_next  = ST_OK;
            state_next = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd.walk = 1'b1;
        cmd.mark = 1'b1;
        if (stat.walk_last) begin
          state_next = S_DONE;
        end
      end
      S_DREAD: begin
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.dload  = 1'b1;
        code_next  = ST_OK;
        state_next = S_FREE;
      end
      S_FREE: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

### rtl/cba_dp.sv
`timescale 1ns / 1ps
module cba_dp
  import cba_pkg::*;
#(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int NUM_FILES   = NUM_FILES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cba_cmd_t            cmd,
  output cba_stat_t           stat,
  input  logic                op,
  input  logic [SIZE_W-1:0]   size_bytes,
  input  logic [ENTRY_W-1:0]  entry_index,
  input  logic                m_tready,
  output logic                m_tvalid,
  output status_t             status,
  output logic [ENTRY_W-1:0]  entry_out,
  output logic [FIRST_W-1:0]  first_block,
  output logic [COUNT_W-1:0]  run_blocks
);

  localparam int BAW = $clog2(NUM_BLOCKS);
  localparam int RW  = $clog2(NUM_BLOCKS + 1);
  localparam int EW  = $clog2(NUM_FILES);
  localparam logic [BAW-1:0] LAST_BLK = BAW'(NUM_BLOCKS - 1);
  localparam logic [EW-1:0]  LAST_ENT = EW'(NUM_FILES - 1);

  // Reciprocal of the block size, exact for any dividend below 2**DVD_W
  localparam int BBW = $clog2(BLOCK_BYTES);
  localparam int RSH = DVD_W + BBW;
  localparam int RCW = DVD_W + 1;
  localparam int PW  = DVD_W + RCW;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RSH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [RCW-1:0] RECIP = RCW'(RECIP_FULL);

  // Clearing pass
  logic [BAW-1:0] clr_addr;

  // Divider
  logic             div_act;
  logic [DVD_W-1:0] dvd;
  logic [DVD_W-1:0] quo;
  logic [PW-1:0]    prod;

  // Entry scan
  logic [NUM_FILES-1:0] ent_valid;
  logic [EW-1:0]        ent_ptr;
  logic [EW-1:0]        idx_in;
  logic                 ent_act;
  logic                 ent_found;

  // Block scan
  logic           blk_act;
  logic           blk_found;
  logic           iss;
  logic           pend;
  logic [BAW-1:0] rd_addr;
  logic [BAW-1:0] chk_addr;
  logic [RW-1:0]  run;
  logic [RW-1:0]  run_inc;
  logic [BAW-1:0] blk_start;
  logic           used_q;

  // Run walk and recorded run
  logic [BAW-1:0] ptr;
  logic [RW-1:0]  wrem;
  logic [BAW-1:0] run_start;
  logic [RW-1:0]  run_count;

  // Block map port
  logic           bm_we;
  logic [BAW-1:0] bm_waddr;

  // Entry table port
  logic [BAW+RW-1:0] tbl_rdata;

  logic start_scans;

  assign start_scans = cmd.load && (op == OP_CREATE) && (size_bytes != '0);
  assign idx_in      = EW'(entry_index);

  // Status to controller
  assign stat.clr_last  = (clr_addr == LAST_BLK);
  assign stat.div_done  = !div_act;
  assign stat.scan_done = !blk_act && !ent_act;
  assign stat.ent_found = ent_found;
  assign stat.blk_found = blk_found;
  assign stat.walk_last = (wrem == RW'(1));
  assign stat.size_zero = (size_bytes == '0);
  assign stat.del_bad   = (32'(entry_index) >= 32'(NUM_FILES)) || !ent_valid[idx_in];
  assign stat.op        = op;
  assign stat.out_free  = !m_tvalid || m_tready;

  // Step the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + BAW'(1);
    end
  end

  // Round the size up to blocks: register the dividend, then one multiply
  assign prod = PW'(dvd) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_act <= 1'b0;
    end else if (cmd.load) begin
      div_act <= start_scans;
    end else if (div_act) begin
      div_act <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd <= DVD_W'(size_bytes) + DVD_W'(BLOCK_BYTES - 1);
    end else if (div_act) begin
      quo <= DVD_W'(prod >> RSH);
    end
  end

  // Find the lowest free entry, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_act   <= 1'b0;
      ent_found <= 1'b0;
      ent_ptr   <= '0;
    end else if (cmd.load) begin
      ent_act   <= start_scans;
      ent_found <= 1'b0;
      ent_ptr   <= (op == OP_CREATE) ? '0 : idx_in;
    end else if (ent_act) begin
      if (!ent_valid[ent_ptr]) begin
        ent_found <= 1'b1;
        ent_act   <= 1'b0;
      end else if (ent_ptr == LAST_ENT) begin
        ent_act <= 1'b0;
      end else begin
        ent_ptr <= ent_ptr + EW'(1);
      end
    end
  end

  // Set or drop entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (cmd.commit) begin
      ent_valid[ent_ptr] <= 1'b1;
    end else if (cmd.dload) begin
      ent_valid[ent_ptr] <= 1'b0;
    end
  end

  // First-fit scan: issue one block read a cycle, check it the next
  assign run_inc = run + RW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_act   <= 1'b0;
      blk_found <= 1'b0;
      iss       <= 1'b0;
      pend      <= 1'b0;
      rd_addr   <= '0;
      run       <= '0;
    end else if (cmd.scan_go) begin
      blk_act   <= 1'b1;
      blk_found <= 1'b0;
      iss       <= 1'b1;
      pend      <= 1'b0;
      rd_addr   <= '0;
      run       <= '0;
    end else if (blk_act) begin
      pend <= iss;
      if (iss) begin
        if (rd_addr == LAST_BLK) begin
          iss <= 1'b0;
        end else begin
          rd_addr <= rd_addr + BAW'(1);
        end
      end
      if (pend) begin
        if (used_q) begin
          run <= '0;
        end else begin
          run <= run_inc;
        end
        if (!used_q && (DVD_W'(run_inc) == quo)) begin
          blk_found <= 1'b1;
          blk_act   <= 1'b0;
        end else if (chk_addr == LAST_BLK) begin
          blk_act <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr <= rd_addr;
    if (blk_act && pend && !used_q && (DVD_W'(run_inc) == quo)) begin
      blk_start <= chk_addr + BAW'(1) - quo[BAW-1:0];
    end
  end

  // Walk the run, writing one block a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wrem <= '0;
    end else if (cmd.commit) begin
      wrem <= quo[RW-1:0];
    end else if (cmd.dload) begin
      wrem <= tbl_rdata[RW-1:0];
    end else if (cmd.walk) begin
      wrem <= wrem - RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ptr       <= blk_start;
      run_start <= blk_start;
      run_count <= quo[RW-1:0];
    end else if (cmd.dload) begin
      ptr       <= tbl_rdata[BAW+RW-1:RW];
      run_start <= tbl_rdata[BAW+RW-1:RW];
      run_count <= tbl_rdata[RW-1:0];
    end else if (cmd.walk) begin
      ptr <= ptr + BAW'(1);
    end
  end

  // Block-in-use map
  assign bm_we    = cmd.clr || cmd.walk;
  assign bm_waddr = cmd.clr ? clr_addr : ptr;

  cba_ram #(
    .WIDTH (1),
    .DEPTH (NUM_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (cmd.mark),
    .raddr (rd_addr),
    .rdata (used_q)
  );

  // Entry table: start block and block count
  cba_ram #(
    .WIDTH (BAW + RW),
    .DEPTH (NUM_FILES)
  ) u_tbl (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (ent_ptr),
    .wdata ({blk_start, quo[RW-1:0]}),
    .raddr (ent_ptr),
    .rdata (tbl_rdata)
  );

  // Output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= cmd.res_code;
      if (cmd.res_code == ST_OK) begin
        entry_out   <= ENTRY_W'(ent_ptr);
        first_block <= FIRST_W'(run_start);
        run_blocks  <= COUNT_W'(run_count);
      end else begin
        entry_out   <= '0;
        first_block <= '0;
        run_blocks  <= '0;
      end
    end
  end

endmodule

### rtl/cba_checker.sv
`timescale 1ns / 1ps
`include "contiguous_block_allocator_top_defines.svh"
module cba_checker
  import cba_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [DATA_W-1:0]   s_tdata,
  input logic                s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [DATA_W-1:0]   m_tdata,
  input logic [STATUS_W-1:0] m_tuser
);

  // Stalled result holds
  `CBA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // Error results carry zero fields
  `CBA_ASSERT_SAME(a_err_zero, m_tvalid && (m_tuser != ST_OK), m_tdata == '0, "error result with nonzero fields")

  // One request at a time: busy right after an accept
  `CBA_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "input ready right after accept")

  // No result can appear the cycle after an accept
  `CBA_ASSERT_NEXT(a_no_early, s_tvalid && s_tready, !$rose(m_tvalid), "result raised too early")

endmodule

bind contiguous_block_allocator_top cba_checker u_chk (.*);
